// ===== rtl/hdu_pkg.sv =====
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants of the half-duplex UART bit engine.
// ----------------------------------------------------------------------------
package hdu_pkg;

   localparam int TxQueueDepth   = 128;
   localparam int QueueAddrWidth = $clog2(TxQueueDepth);
   localparam int QueueFillWidth = $clog2(TxQueueDepth + 1);

   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;

   localparam logic [1:0] ModeIdle     = 2'd0;
   localparam logic [1:0] ModeReceive  = 2'd1;
   localparam logic [1:0] ModeTransmit = 2'd2;

   localparam logic [3:0] LastDataCount = 4'd8;
   localparam logic [3:0] StopCount     = 4'd9;

   typedef struct packed {
      logic       rx_level;
      logic       push_valid;
      logic [7:0] push_byte;
   } req_payload_type;

   typedef struct packed {
      logic       tx_level;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_done;
      logic       push_dropped;
   } rsp_payload_type;

   typedef struct packed {
      logic       pop;
      logic       push;
      logic [7:0] push_byte;
   } queue_ctl_type;

   typedef struct packed {
      logic       not_empty;
      logic [7:0] head_byte;
      logic       dropped;
   } queue_status_type;

endpackage

// ===== rtl/hdu_tx_queue.sv =====
// ----------------------------------------------------------------------------
// hdu_tx_queue
// Transmit byte queue: a memory with head, tail and fill count. The byte at
// the head is kept in a read register that follows the next head address.
// ----------------------------------------------------------------------------
module hdu_tx_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  hdu_pkg::queue_ctl_type    ctl,
   output hdu_pkg::queue_status_type status
);
   import hdu_pkg::*;

   logic [7:0]                mem [TxQueueDepth];
   logic [7:0]                rd_ff;
   logic [QueueAddrWidth-1:0] head_ff, head_in;
   logic [QueueAddrWidth-1:0] tail_ff, tail_in;
   logic [QueueFillWidth-1:0] fill_ff, fill_in;
   logic [QueueFillWidth-1:0] fill_after;
   logic                      do_pop, do_push, full_after;

   function automatic logic [QueueAddrWidth-1:0] next_slot(
      input logic [QueueAddrWidth-1:0] idx);
      if (idx == QueueAddrWidth'(TxQueueDepth - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   always_comb begin
      do_pop     = ctl.pop && (fill_ff != '0);
      fill_after = fill_ff - QueueFillWidth'(do_pop);
      full_after = (fill_after == QueueFillWidth'(TxQueueDepth));
      do_push    = ctl.push && !full_after;
      head_in    = do_pop ? next_slot(head_ff) : head_ff;
      tail_in    = do_push ? next_slot(tail_ff) : tail_ff;
      fill_in    = fill_after + QueueFillWidth'(do_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= ctl.push_byte;
      end
      if (do_push && (tail_ff == head_in)) begin
         rd_ff <= ctl.push_byte;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   assign status.not_empty = (fill_ff != '0);
   assign status.head_byte = rd_ff;
   assign status.dropped   = ctl.push && full_after;

endmodule

// ===== rtl/hdu_bit_core.sv =====
// ----------------------------------------------------------------------------
// hdu_bit_core
// Per-tick receive and transmit state: bit counter, start flag, shift
// registers, load step and line level, advanced once per transfer.
// ----------------------------------------------------------------------------
module hdu_bit_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      clear_start,
   input  logic [1:0]                link_mode,
   input  hdu_pkg::req_payload_type  req,
   input  hdu_pkg::queue_status_type qstat,
   output hdu_pkg::queue_ctl_type    qctl,
   output hdu_pkg::rsp_payload_type  result
);
   import hdu_pkg::*;

   logic [3:0] count_ff, count_in, count_inc;
   logic       start_ff, start_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [7:0] tx_shift_ff, tx_shift_in;
   logic       loaded_ff, loaded_in;
   logic       line_ff, line_in;
   logic       rx_valid, tx_done;
   logic [7:0] rx_out;

   always_comb begin
      count_in    = count_ff;
      start_in    = start_ff;
      rx_shift_in = rx_shift_ff;
      tx_shift_in = tx_shift_ff;
      loaded_in   = loaded_ff;
      line_in     = line_ff;
      rx_valid    = 1'b0;
      rx_out      = '0;
      tx_done     = 1'b0;
      count_inc   = count_ff + 4'd1;
      unique case (link_mode)
         ModeReceive: begin
            if (!start_ff) begin
               if (!req.rx_level) begin
                  start_in    = 1'b1;
                  rx_shift_in = '0;
                  count_in    = '0;
               end
            end else begin
               count_in = (count_ff < StopCount) ? count_inc : count_ff;
               if (count_in <= LastDataCount) begin
                  rx_shift_in = {rx_shift_ff[7] | req.rx_level, rx_shift_ff[6:0]};
                  if (count_in < LastDataCount) begin
                     rx_shift_in = {1'b0, rx_shift_in[7:1]};
                  end
               end else if (req.rx_level) begin
                  rx_valid = 1'b1;
                  rx_out   = rx_shift_ff;
                  start_in = 1'b0;
                  count_in = '0;
               end
            end
         end
         ModeTransmit: begin
            if (!loaded_ff) begin
               if (qstat.not_empty) begin
                  tx_shift_in = qstat.head_byte;
                  loaded_in   = 1'b1;
                  count_in    = '0;
               end
            end else if (!start_ff) begin
               start_in = 1'b1;
               line_in  = 1'b0;
            end else begin
               count_in = count_inc;
               if ((count_inc >= 4'd1) && (count_inc <= LastDataCount)) begin
                  line_in     = tx_shift_ff[0];
                  tx_shift_in = {1'b0, tx_shift_ff[7:1]};
               end else if (count_inc == StopCount) begin
                  start_in  = 1'b0;
                  line_in   = 1'b1;
                  tx_done   = 1'b1;
                  count_in  = '0;
                  loaded_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         start_ff    <= 1'b0;
         rx_shift_ff <= '0;
         tx_shift_ff <= '0;
         loaded_ff   <= 1'b0;
         line_ff     <= 1'b1;
      end else begin
         if (clear_start) begin
            start_ff <= 1'b0;
         end else if (step) begin
            start_ff <= start_in;
         end
         if (step) begin
            count_ff    <= count_in;
            rx_shift_ff <= rx_shift_in;
            tx_shift_ff <= tx_shift_in;
            loaded_ff   <= loaded_in;
            line_ff     <= line_in;
         end
      end
   end

   assign qctl.pop       = step && tx_done;
   assign qctl.push      = step && req.push_valid;
   assign qctl.push_byte = req.push_byte;

   assign result.tx_level     = line_in;
   assign result.rx_valid     = rx_valid;
   assign result.rx_byte      = rx_out;
   assign result.tx_done      = tx_done;
   assign result.push_dropped = qstat.dropped;

endmodule

// ===== rtl/half_duplex_uart_bit_engine.sv =====
// ----------------------------------------------------------------------------
// half_duplex_uart_bit_engine
// Half-duplex 8N1 UART advanced by one bit-time tick per request transfer,
// with a transmit byte queue and a mode register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  rx_level, push_valid, push_byte
//   rsp_      out        rsp_valid/rsp_ready  tx_level, rx_valid, rx_byte,
//                                             tx_done, push_dropped
//   csr_      in         APB psel/penable     link_mode, paddr not decoded
//
// Each tick is worked in the cycle of its transfer and its result appears in
// the output register in the next cycle; one tick per clock is sustained
// unless a result waits and rsp_ready is low; only then do requests stall.
// The queue memory needs no clearing pass; reset only clears its pointers.
// Synchronous active-high reset puts the line idle high and the mode idle.
// ----------------------------------------------------------------------------
module half_duplex_uart_bit_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hdu_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hdu_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hdu_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [hdu_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [hdu_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import hdu_pkg::*;

   logic             step;
   logic             csr_write;
   logic [1:0]       mode_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff, rsp_in;
   queue_ctl_type    qctl;
   queue_status_type qstat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = CsrDataWidth'(mode_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeIdle;
      end else if (csr_write) begin
         mode_ff <= csr_pwdata[1:0];
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   hdu_bit_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .clear_start (csr_write),
      .link_mode   (mode_ff),
      .req         (req_payload),
      .qstat       (qstat),
      .qctl        (qctl),
      .result      (rsp_in)
   );

   hdu_tx_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (qctl),
      .status (qstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_step_gives_result : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted tick did not produce a result");

   a_stall_only_on_result : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a waiting result");

   a_done_line_high : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.tx_done) |-> rsp_payload.tx_level)
      else $error("stop bit reported with line low");

   a_rx_tx_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.rx_valid && rsp_payload.tx_done))
      else $error("receive and transmit events in one tick");

endmodule

// ===== tb/half_duplex_uart_bit_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_bit_engine_tb
// Self-checking bench for the half-duplex UART bit engine. Every tick transfer
// is run through a local model of the receiver, the transmitter and the byte
// queue, and each result transfer is compared field by field with the oldest
// prediction. Directed tests cover the idle and unused modes, whole frames,
// low stop bits, abandoned frames and queue overflow. Random phases of framed
// line traffic follow, with random gaps on both channels and one long output
// stall.
// ----------------------------------------------------------------------------
module half_duplex_uart_bit_engine_tb;
   import hdu_pkg::*;

   localparam logic [CsrAddrWidth-1:0] LinkModeAddr = '0;
   localparam logic [1:0] ModeUnused = 2'd3;
   localparam int RandomItems    = 850;
   localparam int QuietTailItems = 150;
   localparam int LongHoldCycles = 200;
   localparam int SettleCycles   = 4;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_payload;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   logic [1:0] link_mode_now;
   logic [3:0] bit_ctr;
   logic frame_open;
   logic [7:0] rx_shreg;
   logic [7:0] tx_shreg;
   logic byte_loaded;
   logic line_level;
   logic [7:0] txq_mem [TxQueueDepth];
   logic [QueueAddrWidth-1:0] txq_head;
   logic [QueueAddrWidth-1:0] txq_tail;
   logic [QueueFillWidth-1:0] txq_fill;

   rsp_payload_type due_results[$];
   rsp_payload_type oldest_due;

   logic quiet_tail;
   logic hold_request;
   int error_count;
   int ticks_sent;
   int bytes_received;
   int frames_sent;
   int pushes_dropped;
   int mode_writes;
   int input_stall_cycles;

   half_duplex_uart_bit_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic logic [QueueAddrWidth-1:0] queue_next(
      input logic [QueueAddrWidth-1:0] idx);
      return (int'(idx) == TxQueueDepth - 1) ? '0 : idx + 1'b1;
   endfunction

   function automatic rsp_payload_type advance_tick(input req_payload_type t);
      rsp_payload_type r;
      r = '0;
      if (link_mode_now == ModeReceive) begin
         if (!frame_open) begin
            if (!t.rx_level) begin
               frame_open = 1'b1;
               rx_shreg = '0;
               bit_ctr = '0;
            end
         end else begin
            if (bit_ctr < StopCount) begin
               bit_ctr = bit_ctr + 4'd1;
            end
            if (bit_ctr <= LastDataCount) begin
               if (t.rx_level) begin
                  rx_shreg[7] = 1'b1;
               end
               if (bit_ctr < LastDataCount) begin
                  rx_shreg = rx_shreg >> 1;
               end
            end else if (t.rx_level) begin
               r.rx_valid = 1'b1;
               r.rx_byte = rx_shreg;
               frame_open = 1'b0;
               bit_ctr = '0;
            end
         end
      end else if (link_mode_now == ModeTransmit) begin
         if (!byte_loaded) begin
            if (txq_fill > 0) begin
               tx_shreg = txq_mem[txq_head];
               byte_loaded = 1'b1;
               bit_ctr = '0;
            end
         end else if (!frame_open) begin
            frame_open = 1'b1;
            line_level = 1'b0;
         end else begin
            bit_ctr = bit_ctr + 4'd1;
            if (bit_ctr >= 4'd1 && bit_ctr <= LastDataCount) begin
               line_level = tx_shreg[0];
               tx_shreg = tx_shreg >> 1;
            end else if (bit_ctr == StopCount) begin
               frame_open = 1'b0;
               line_level = 1'b1;
               r.tx_done = 1'b1;
               bit_ctr = '0;
               if (txq_fill > 0) begin
                  txq_head = queue_next(txq_head);
                  txq_fill = txq_fill - 1'b1;
               end
               byte_loaded = 1'b0;
            end
         end
      end
      if (t.push_valid) begin
         if (int'(txq_fill) < TxQueueDepth) begin
            txq_mem[txq_tail] = t.push_byte;
            txq_tail = queue_next(txq_tail);
            txq_fill = txq_fill + 1'b1;
         end else begin
            r.push_dropped = 1'b1;
         end
      end
      r.tx_level = line_level;
      return r;
   endfunction

   task automatic send_tick(input logic level, input logic push, input logic [7:0] data);
      req_payload_type tick;
      int gap;
      tick.rx_level = level;
      tick.push_valid = push;
      tick.push_byte = data;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= tick;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(advance_tick(tick));
      ticks_sent++;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // The mode register is only written once every pending tick has come back.
   task automatic write_link_mode(input logic [1:0] mode);
      drain_results();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LinkModeAddr;
      csr_pwdata <= CsrDataWidth'(mode);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      link_mode_now = mode;
      frame_open = 1'b0;
      mode_writes++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CsrDataWidth'(mode)) begin
         error_count++;
         $display("%0t ns: link_mode readback mismatch, expected %0h, actual %0h",
                  $time, CsrDataWidth'(mode), csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic test_idle_and_unused_mode();
      write_link_mode(ModeIdle);
      send_tick(1'b0, 1'b1, 8'h00);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b0, 1'b0, 8'hFF);
      write_link_mode(ModeUnused);
      send_tick(1'b0, 1'b1, 8'h01);
      send_tick(1'b1, 1'b0, 8'h00);
   endtask

   // One whole frame, then a second byte left partly sent.
   task automatic test_transmit_frame();
      write_link_mode(ModeTransmit);
      repeat (11) send_tick(1'($urandom_range(0, 1)), 1'b0, 8'h00);
      repeat (4) send_tick(1'($urandom_range(0, 1)), 1'b0, 8'h00);
   endtask

   // A frame with two low stop bits, then a frame abandoned at its stop bit.
   task automatic test_receive_frames();
      logic [7:0] data;
      int b;
      write_link_mode(ModeReceive);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      data = 8'hA5;
      for (b = 0; b < 8; b++) send_tick(data[b], 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      data = 8'h3C;
      for (b = 0; b < 8; b++) send_tick(data[b], 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
   endtask

   // The half-sent byte restarts with the counter at nine, so it wraps first.
   task automatic test_resume_after_abandon();
      write_link_mode(ModeTransmit);
      repeat (17) send_tick(1'($urandom_range(0, 1)), 1'b0, 8'h00);
   endtask

   task automatic test_output_backpressure();
      write_link_mode(ModeReceive);
      hold_request = 1'b1;
      repeat (30) send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                            8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_traffic(input int total);
      int sent;
      int phase_len;
      int pick;
      int i;
      int b;
      logic [1:0] mode;
      logic level;
      logic [7:0] frame_data;
      bit line_plan[$];
      sent = 0;
      while (sent < total) begin
         pick = $urandom_range(0, 9);
         mode = (pick == 0) ? ModeIdle :
                (pick == 1) ? ModeUnused :
                (pick < 6)  ? ModeReceive : ModeTransmit;
         write_link_mode(mode);
         line_plan.delete();
         phase_len = $urandom_range(8, 80);
         for (i = 0; i < phase_len && sent < total; i++) begin
            if (total - sent < QuietTailItems) begin
               quiet_tail = 1'b1;
            end
            if (mode == ModeReceive) begin
               if (line_plan.size() == 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     repeat ($urandom_range(1, 6))
                        line_plan.push_back(1'($urandom_range(0, 1)));
                  end else begin
                     repeat ($urandom_range(0, 3)) line_plan.push_back(1'b1);
                     line_plan.push_back(1'b0);
                     frame_data = 8'($urandom_range(0, 255));
                     for (b = 0; b < 8; b++) line_plan.push_back(frame_data[b]);
                     if ($urandom_range(0, 5) == 0) begin
                        repeat ($urandom_range(1, 3)) line_plan.push_back(1'b0);
                     end
                     line_plan.push_back(1'b1);
                  end
               end
               level = line_plan.pop_front();
            end else begin
               level = 1'($urandom_range(0, 1));
            end
            send_tick(level, $urandom_range(0, 99) < ((mode == ModeTransmit) ? 20 : 10),
                      8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   // Fill the queue past its depth, then let the transmitter free one slot.
   task automatic test_queue_overflow();
      int room;
      write_link_mode(ModeIdle);
      room = TxQueueDepth - int'(txq_fill) + 2;
      repeat (room) send_tick(1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 255)));
      write_link_mode(ModeTransmit);
      repeat (24) send_tick(1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 255)));
   endtask

   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LongHoldCycles - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t ns: result transfer with no tick pending, expected none, actual %h",
                     $time, rsp_payload);
         end else begin
            oldest_due = due_results.pop_front();
            check_field("tx_level", 8'(oldest_due.tx_level), 8'(rsp_payload.tx_level));
            check_field("rx_valid", 8'(oldest_due.rx_valid), 8'(rsp_payload.rx_valid));
            check_field("rx_byte", oldest_due.rx_byte, rsp_payload.rx_byte);
            check_field("tx_done", 8'(oldest_due.tx_done), 8'(rsp_payload.tx_done));
            check_field("push_dropped", 8'(oldest_due.push_dropped),
                        8'(rsp_payload.push_dropped));
            if (oldest_due.rx_valid) bytes_received++;
            if (oldest_due.tx_done) frames_sent++;
            if (oldest_due.push_dropped) pushes_dropped++;
         end
      end
   end

   initial begin
      #4000000;
      $display("half_duplex_uart_bit_engine verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet_tail = 1'b0;
      hold_request = 1'b0;
      error_count = 0;
      ticks_sent = 0;
      bytes_received = 0;
      frames_sent = 0;
      pushes_dropped = 0;
      mode_writes = 0;
      input_stall_cycles = 0;
      link_mode_now = ModeIdle;
      bit_ctr = '0;
      frame_open = 1'b0;
      rx_shreg = '0;
      tx_shreg = '0;
      byte_loaded = 1'b0;
      line_level = 1'b1;
      txq_head = '0;
      txq_tail = '0;
      txq_fill = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_and_unused_mode();
      test_transmit_frame();
      test_receive_frames();
      test_resume_after_abandon();
      test_output_backpressure();
      test_random_traffic(RandomItems);
      test_queue_overflow();

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      $display("Ran %0d ticks over %0d mode writes: %0d bytes received, %0d frames sent.",
               ticks_sent, mode_writes, bytes_received, frames_sent);
      $display("Queue overflow dropped %0d pushes; the input was stalled for %0d cycles.",
               pushes_dropped, input_stall_cycles);
      if (error_count == 0) begin
         $display("half_duplex_uart_bit_engine verification clean");
      end else begin
         $display("half_duplex_uart_bit_engine verification failed");
      end
      $finish;
   end

endmodule
